// ----- rtl/i2cms_pkg.sv -----
// Package with the codes and result type of the I2C master status sequencer.
package i2cms_pkg;

    // Control actions handed to the byte-level controller.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_CLEAR   = 3'd1;
    localparam logic [2:0] ACT_ACK     = 3'd2;
    localparam logic [2:0] ACT_STOP    = 3'd3;
    localparam logic [2:0] ACT_RESTART = 3'd4;
    localparam logic [2:0] ACT_ERRSTOP = 3'd5;
    localparam logic [2:0] ACT_START   = 3'd6;
    localparam logic [2:0] ACT_TIMEOUT = 3'd7;

    // Transfer modes.
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_WRITE    = 2'd1;
    localparam logic [1:0] MODE_READ_ONE = 2'd2;
    localparam logic [1:0] MODE_READ_RUN = 2'd3;

    // Input word kinds.
    localparam logic FUNC_START = 1'b0;

    // Controller status codes.
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_AW_ACK     = 8'h18;
    localparam logic [7:0] ST_AW_NACK    = 8'h20;
    localparam logic [7:0] ST_DW_ACK     = 8'h28;
    localparam logic [7:0] ST_DW_NACK    = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_AR_ACK     = 8'h40;
    localparam logic [7:0] ST_AR_NACK    = 8'h48;
    localparam logic [7:0] ST_DR_ACK     = 8'h50;
    localparam logic [7:0] ST_DR_NACK    = 8'h58;

    // Read/write bit appended to the target address.
    localparam logic RW_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TRANSFER_MODE    = 3'd0;
    localparam logic [2:0] CFG_TARGET_ADDRESS   = 3'd1;
    localparam logic [2:0] CFG_REGISTER_ADDRESS = 3'd2;
    localparam logic [2:0] CFG_WRITE_VALUE      = 3'd3;
    localparam logic [2:0] CFG_READ_LENGTH      = 3'd4;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0] action;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [7:0] read_index;
        logic       done_res;
        logic       error;
    } result_t;

endpackage

// ----- rtl/i2c_master_status_sequencer.sv -----
// Top level of the I2C master status sequencer: input stage, status decode, result stage.
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_tvalid / s_tready    | s_tdata (status, byte, timeout), s_tuser (func)
//  m_      | out       | m_tvalid / m_tready    | m_tdata (action, send, read, flags)
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each word passes through the input register and then through the status decode into the
// result register. One word is accepted per cycle while m_ does not stall.
// The transaction state updates as a word moves into the result register.
// A stall on m_ holds the result register and then the input register in turn.
// Reset clears the valid flags, the transaction state and the configuration, but the read length resets to one.
module i2c_master_status_sequencer import i2cms_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] status_code, [15:8] bus_byte, [16] timeout_seen, [23:17] zero
    input  logic [23:0] s_tdata,
    // [0] func
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] action, [3] send_valid, [11:4] send_byte, [12] read_valid,
    // [20:13] read_byte, [28:21] read_index, [29] done_res, [30] error, [31] zero
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [1:0] mode_reg;
    logic [6:0] target_reg;
    logic [7:0] regaddr_reg;
    logic [7:0] wvalue_reg;
    logic [7:0] rlength_reg;

    logic       in_valid_reg;
    logic       func_reg;
    logic [7:0] status_reg;
    logic [7:0] bus_reg;
    logic       tmo_reg;

    logic       out_valid_reg;
    result_t    res_reg;
    result_t    res_next;

    logic       data_sent_reg;
    logic       data_sent_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;

    logic       advance;
    logic [7:0] wr_addr;
    logic [7:0] rd_addr;
    logic [8:0] ack_limit;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, res_reg.error, res_reg.done_res, res_reg.read_index,
                        res_reg.read_byte, res_reg.read_valid, res_reg.send_byte,
                        res_reg.send_valid, res_reg.action};

    assign wr_addr   = {target_reg, 1'b0};
    assign rd_addr   = {target_reg, RW_READ};
    // More bytes follow while the count after this byte plus one stays below the length.
    assign ack_limit = {1'b0, count_reg} + 9'd2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            target_reg  <= '0;
            regaddr_reg <= '0;
            wvalue_reg  <= '0;
            rlength_reg <= 8'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TRANSFER_MODE:    mode_reg    <= cfg_data[1:0];
                CFG_TARGET_ADDRESS:   target_reg  <= cfg_data[6:0];
                CFG_REGISTER_ADDRESS: regaddr_reg <= cfg_data;
                CFG_WRITE_VALUE:      wvalue_reg  <= cfg_data;
                CFG_READ_LENGTH:      rlength_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            data_sent_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                data_sent_reg <= data_sent_next;
                count_reg     <= count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg   <= s_tuser[0];
            status_reg <= s_tdata[7:0];
            bus_reg    <= s_tdata[15:8];
            tmo_reg    <= s_tdata[16];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    always_comb begin
        res_next       = '0;
        data_sent_next = data_sent_reg;
        count_next     = count_reg;
        if (func_reg == FUNC_START) begin
            data_sent_next  = 1'b0;
            count_next      = '0;
            res_next.action = (mode_reg == MODE_IDLE) ? ACT_NONE : ACT_START;
        end else if (tmo_reg) begin
            res_next.action = ACT_TIMEOUT;
        end else if (mode_reg == MODE_IDLE) begin
            res_next.action = ACT_NONE;
        end else begin
            unique case (status_reg)
                ST_START: begin
                    res_next.send_valid = 1'b1;
                    res_next.send_byte  = wr_addr;
                    res_next.action     = ACT_CLEAR;
                end
                ST_AW_ACK: begin
                    res_next.send_valid = 1'b1;
                    res_next.send_byte  = regaddr_reg;
                    res_next.action     = ACT_CLEAR;
                end
                ST_AW_NACK, ST_DW_NACK: begin
                    res_next.action = ACT_STOP;
                    res_next.error  = 1'b1;
                end
                ST_DW_ACK: begin
                    if (mode_reg != MODE_WRITE) begin
                        res_next.action = ACT_RESTART;
                    end else if (!data_sent_reg) begin
                        res_next.send_valid = 1'b1;
                        res_next.send_byte  = wvalue_reg;
                        res_next.action     = ACT_CLEAR;
                        data_sent_next      = 1'b1;
                    end else begin
                        res_next.action   = ACT_STOP;
                        res_next.done_res = 1'b1;
                    end
                end
                ST_RESTART: begin
                    if (mode_reg == MODE_WRITE) begin
                        res_next.action = ACT_ERRSTOP;
                        res_next.error  = 1'b1;
                    end else begin
                        res_next.send_valid = 1'b1;
                        res_next.send_byte  = rd_addr;
                        res_next.action     = ACT_CLEAR;
                    end
                end
                ST_AR_ACK: begin
                    if (mode_reg == MODE_WRITE) begin
                        res_next.action = ACT_ERRSTOP;
                        res_next.error  = 1'b1;
                    end else begin
                        res_next.action = (mode_reg == MODE_READ_RUN) ? ACT_ACK : ACT_CLEAR;
                    end
                end
                ST_AR_NACK: begin
                    res_next.action = (mode_reg == MODE_WRITE) ? ACT_ERRSTOP : ACT_STOP;
                    res_next.error  = 1'b1;
                end
                ST_DR_ACK: begin
                    if (mode_reg == MODE_READ_RUN) begin
                        res_next.read_valid = 1'b1;
                        res_next.read_byte  = bus_reg;
                        res_next.read_index = count_reg;
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + 8'd1;
                        end
                        res_next.action = (ack_limit < {1'b0, rlength_reg}) ? ACT_ACK
                                                                            : ACT_CLEAR;
                    end else begin
                        res_next.action = ACT_ERRSTOP;
                        res_next.error  = 1'b1;
                    end
                end
                ST_DR_NACK: begin
                    if (mode_reg == MODE_WRITE) begin
                        res_next.action = ACT_ERRSTOP;
                        res_next.error  = 1'b1;
                    end else begin
                        res_next.read_valid = 1'b1;
                        res_next.read_byte  = bus_reg;
                        if (mode_reg == MODE_READ_RUN) begin
                            res_next.read_index = count_reg;
                            if (count_reg != COUNT_MAX) begin
                                count_next = count_reg + 8'd1;
                            end
                        end
                        res_next.action   = ACT_STOP;
                        res_next.done_res = 1'b1;
                    end
                end
                // Arbitration loss lands here along with every undecoded code.
                default: begin
                    res_next.action = ACT_ERRSTOP;
                    res_next.error  = 1'b1;
                end
            endcase
        end
    end

    // A start word that has moved into the result register leaves a fresh transaction.
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && func_reg == FUNC_START) |=> (count_reg == '0 && !data_sent_reg))
        else $error("start word did not clear the transaction state");

    // A received byte only comes with a clear, an ack or a stop.
    a_read_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.read_valid) |->
            (res_reg.action == ACT_STOP || res_reg.action == ACT_ACK ||
             res_reg.action == ACT_CLEAR))
        else $error("received byte delivered with an unexpected action");

    // Success is reported only with a clean stop.
    a_done_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.done_res) |-> (res_reg.action == ACT_STOP && !res_reg.error))
        else $error("done flag without a clean stop");

    // An error always ends the transfer on the bus.
    a_error_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.error) |->
            (res_reg.action == ACT_STOP || res_reg.action == ACT_ERRSTOP))
        else $error("error flag without a stop");

    // The byte counter moves by at most one per word.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && func_reg != FUNC_START) |=>
            (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 8'd1))
        else $error("byte counter jumped");

endmodule

// ----- tb/i2c_master_status_sequencer_checker.sv -----
// Checker that predicts each result word of the I2C master status sequencer and compares it.
`timescale 1ns / 100ps

module i2c_master_status_sequencer_checker
    import i2cms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatch_count,
    output int          results_pending
);

    // Register copies.
    logic [1:0] xfer_mode   = MODE_IDLE;
    logic [6:0] dev_addr    = '0;
    logic [7:0] reg_addr    = '0;
    logic [7:0] wr_value    = '0;
    logic [7:0] rd_length   = 8'd1;

    // Transaction state.
    logic       wr_data_sent = 1'b0;
    logic [7:0] rx_count     = '0;
    logic       xfer_ok      = 1'b0;

    result_t expected_results[$];

    initial begin
        mismatch_count  = 0;
        results_pending = 0;
    end

    function automatic result_t predict_result(input logic fn, input logic [7:0] st,
                                               input logic [7:0] bus, input logic tmo);
        result_t    r;
        logic [7:0] wr_addr;
        logic [7:0] rd_addr;
        r       = '0;
        wr_addr = {dev_addr, 1'b0};
        rd_addr = {dev_addr, RW_READ};
        if (fn == FUNC_START) begin
            wr_data_sent = 1'b0;
            rx_count     = '0;
            xfer_ok      = 1'b0;
            r.action     = (xfer_mode == MODE_IDLE) ? ACT_NONE : ACT_START;
        end else if (tmo) begin
            r.action = ACT_TIMEOUT;
        end else if (xfer_mode == MODE_IDLE) begin
            r.action = ACT_NONE;
        end else begin
            case (st)
                ST_START: begin
                    r.send_valid = 1'b1;
                    r.send_byte  = wr_addr;
                    r.action     = ACT_CLEAR;
                end
                ST_AW_ACK: begin
                    r.send_valid = 1'b1;
                    r.send_byte  = reg_addr;
                    r.action     = ACT_CLEAR;
                end
                ST_AW_NACK, ST_DW_NACK: begin
                    r.action = ACT_STOP;
                    r.error  = 1'b1;
                end
                ST_DW_ACK: begin
                    if (xfer_mode == MODE_WRITE) begin
                        if (!wr_data_sent) begin
                            r.send_valid = 1'b1;
                            r.send_byte  = wr_value;
                            r.action     = ACT_CLEAR;
                            wr_data_sent = 1'b1;
                        end else begin
                            r.action   = ACT_STOP;
                            r.done_res = 1'b1;
                            xfer_ok    = 1'b1;
                        end
                    end else begin
                        r.action = ACT_RESTART;
                    end
                end
                ST_RESTART: begin
                    if (xfer_mode == MODE_WRITE) begin
                        r.action = ACT_ERRSTOP;
                        r.error  = 1'b1;
                    end else begin
                        r.send_valid = 1'b1;
                        r.send_byte  = rd_addr;
                        r.action     = ACT_CLEAR;
                    end
                end
                ST_AR_ACK: begin
                    if (xfer_mode == MODE_WRITE) begin
                        r.action = ACT_ERRSTOP;
                        r.error  = 1'b1;
                    end else begin
                        r.action = (xfer_mode == MODE_READ_RUN) ? ACT_ACK : ACT_CLEAR;
                    end
                end
                ST_AR_NACK: begin
                    r.action = (xfer_mode == MODE_WRITE) ? ACT_ERRSTOP : ACT_STOP;
                    r.error  = 1'b1;
                end
                ST_DR_ACK: begin
                    if (xfer_mode == MODE_READ_RUN) begin
                        r.read_valid = 1'b1;
                        r.read_byte  = bus;
                        r.read_index = rx_count;
                        if (rx_count != COUNT_MAX)
                            rx_count = rx_count + 8'd1;
                        // Keep acking while at least two more bytes are still wanted.
                        r.action = (int'(r.read_index) + 2 < int'(rd_length)) ? ACT_ACK
                                                                              : ACT_CLEAR;
                    end else begin
                        r.action = ACT_ERRSTOP;
                        r.error  = 1'b1;
                    end
                end
                ST_DR_NACK: begin
                    if (xfer_mode == MODE_WRITE) begin
                        r.action = ACT_ERRSTOP;
                        r.error  = 1'b1;
                    end else begin
                        r.read_valid = 1'b1;
                        r.read_byte  = bus;
                        if (xfer_mode == MODE_READ_RUN) begin
                            r.read_index = rx_count;
                            if (rx_count != COUNT_MAX)
                                rx_count = rx_count + 8'd1;
                        end
                        r.action   = ACT_STOP;
                        r.done_res = 1'b1;
                        xfer_ok    = 1'b1;
                    end
                end
                default: begin
                    r.action = ACT_ERRSTOP;
                    r.error  = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            xfer_mode    = MODE_IDLE;
            dev_addr     = '0;
            reg_addr     = '0;
            wr_value     = '0;
            rd_length    = 8'd1;
            wr_data_sent = 1'b0;
            rx_count     = '0;
            xfer_ok      = 1'b0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TRANSFER_MODE:    xfer_mode = cfg_data[1:0];
                    CFG_TARGET_ADDRESS:   dev_addr  = cfg_data[6:0];
                    CFG_REGISTER_ADDRESS: reg_addr  = cfg_data;
                    CFG_WRITE_VALUE:      wr_value  = cfg_data;
                    CFG_READ_LENGTH:      rd_length = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_result(s_tuser[0], s_tdata[7:0],
                                                          s_tdata[15:8], s_tdata[16]));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result word %h arrived with no expectation pending", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("action",     8'(want.action),     8'(m_tdata[2:0]));
                    check_field("send_valid", 8'(want.send_valid), 8'(m_tdata[3]));
                    check_field("send_byte",  want.send_byte,      m_tdata[11:4]);
                    check_field("read_valid", 8'(want.read_valid), 8'(m_tdata[12]));
                    check_field("read_byte",  want.read_byte,      m_tdata[20:13]);
                    check_field("read_index", want.read_index,     m_tdata[28:21]);
                    check_field("done_res",   8'(want.done_res),   8'(m_tdata[29]));
                    check_field("error",      8'(want.error),      8'(m_tdata[30]));
                end
            end
        end
        results_pending = expected_results.size();
    end

endmodule

// ----- tb/i2c_master_status_sequencer_tb.sv -----
// Testbench top for the I2C master status sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module i2c_master_status_sequencer_tb;
    import i2cms_pkg::*;

    localparam logic FUNC_EVENT  = ~FUNC_START;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   PHASE_WORDS = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    int          mismatch_count;
    int          results_pending;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          words_sent     = 0;
    logic [1:0]  cur_mode       = MODE_IDLE;
    logic [7:0]  cur_rd_length  = 8'd1;

    i2c_master_status_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2c_master_status_sequencer_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] pick_status();
        case ($urandom_range(15))
            0:  return ST_START;
            1:  return ST_RESTART;
            2:  return ST_AW_ACK;
            3:  return ST_AW_NACK;
            4:  return ST_DW_ACK;
            5:  return ST_DW_NACK;
            6:  return ST_ARB_LOST;
            7:  return ST_AR_ACK;
            8:  return ST_AR_NACK;
            9:  return ST_DR_ACK;
            10: return ST_DR_NACK;
            11: return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // The sender may idle before each word; once valid is up it holds until accepted.
    task automatic send_word(input logic fn, input logic [7:0] st, input logic [7:0] bus,
                             input logic tmo);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {7'd0, tmo, bus, st};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_status(input logic [7:0] st);
        send_word(FUNC_EVENT, st, 8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_start();
        send_word(FUNC_START, pick_status(), 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Lets every outstanding result drain from the two-stage pipeline.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [7:0] mode, input logic [7:0] dev,
                                input logic [7:0] regad, input logic [7:0] wval,
                                input logic [7:0] rdlen);
        wait_idle();
        write_reg(CFG_TRANSFER_MODE, mode);
        write_reg(CFG_TARGET_ADDRESS, dev);
        write_reg(CFG_REGISTER_ADDRESS, regad);
        write_reg(CFG_WRITE_VALUE, wval);
        write_reg(CFG_READ_LENGTH, rdlen);
        cfg_valid     <= 1'b0;
        cur_mode      = mode[1:0];
        cur_rd_length = rdlen;
    endtask

    task automatic send_noise(input int count);
        repeat (count) begin
            send_word(($urandom_range(3) == 0) ? FUNC_START : FUNC_EVENT, pick_status(),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // One well-formed transaction for this mode, sometimes cut short by a random status.
    task automatic send_transaction();
        logic [7:0] seq[$];
        int         run_len;
        int         break_at;
        seq = {ST_START, ST_AW_ACK, ST_DW_ACK};
        case (cur_mode)
            MODE_WRITE:    seq.push_back(ST_DW_ACK);
            MODE_READ_ONE: seq = {seq, ST_RESTART, ST_AR_ACK, ST_DR_NACK};
            default: begin
                if (cur_rd_length >= 1 && cur_rd_length <= 8 && $urandom_range(3) != 0)
                    run_len = cur_rd_length;
                else
                    run_len = $urandom_range(1, 8);
                seq = {seq, ST_RESTART, ST_AR_ACK};
                repeat (run_len - 1) seq.push_back(ST_DR_ACK);
                seq.push_back(ST_DR_NACK);
            end
        endcase
        break_at = ($urandom_range(5) == 0) ? $urandom_range(seq.size() - 1) : -1;
        send_start();
        foreach (seq[i]) begin
            if ($urandom_range(15) == 0)
                send_word(FUNC_EVENT, pick_status(), 8'($urandom_range(255)), 1'b1);
            if (i == break_at) begin
                send_status(pick_status());
                break;
            end
            send_status(seq[i]);
        end
    endtask

    task automatic random_segment();
        logic [7:0] rdlen;
        case ($urandom_range(9))
            0:       rdlen = 8'd0;
            1:       rdlen = 8'd255;
            2:       rdlen = 8'($urandom_range(255));
            default: rdlen = 8'($urandom_range(1, 8));
        endcase
        program_regs({6'($urandom_range(63)), 2'($urandom_range(3))}, pick_byte(),
                     pick_byte(), pick_byte(), rdlen);
        repeat ($urandom_range(2, 5)) begin
            if (cur_mode == MODE_IDLE || $urandom_range(3) == 0)
                send_noise($urandom_range(1, 6));
            else
                send_transaction();
        end
    endtask

    initial begin
        int phase_end;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers still at their reset values: idle mode and a timeout event.
        send_start();
        send_status(ST_START);
        send_word(FUNC_EVENT, ST_DW_ACK, 8'hFF, 1'b1);

        program_regs(8'(MODE_WRITE), 8'h7F, 8'hFF, 8'h00, 8'h00);
        send_start();
        send_status(ST_START);
        send_status(ST_AW_ACK);
        send_status(ST_DW_ACK);
        send_word(FUNC_EVENT, ST_DW_ACK, 8'h00, 1'b1);
        send_status(ST_DW_ACK);
        send_status(ST_AW_NACK);
        send_status(ST_DW_NACK);
        send_status(ST_RESTART);
        send_status(ST_ARB_LOST);
        send_status(8'h00);
        send_status(ST_DR_NACK);

        program_regs(8'(MODE_READ_ONE), 8'h00, 8'h00, 8'hFF, 8'hFF);
        send_start();
        send_status(ST_START);
        send_status(ST_AW_ACK);
        send_status(ST_DW_ACK);
        send_status(ST_RESTART);
        send_status(ST_AR_ACK);
        send_word(FUNC_EVENT, ST_DR_NACK, 8'hFF, 1'b0);

        // A zero read length behaves like one byte, so the first received byte gets a clear, not an ack.
        program_regs(8'(MODE_READ_RUN), 8'h55, 8'hAA, 8'h5A, 8'h00);
        send_start();
        send_status(ST_AR_ACK);
        send_status(ST_DR_ACK);
        send_status(ST_DR_NACK);
        send_status(8'hFF);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (phase == 0) begin
                // Long run so the byte index saturates.
                program_regs(8'(MODE_READ_RUN), 8'h3C, 8'h81, 8'h00, 8'hFF);
                send_start();
                send_status(ST_START);
                send_status(ST_AW_ACK);
                send_status(ST_DW_ACK);
                send_status(ST_RESTART);
                send_status(ST_AR_ACK);
                repeat (258) send_status(ST_DR_ACK);
                send_status(ST_DR_NACK);
            end
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) random_segment();
        end

        wait_idle();
        repeat (6) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/i2cms_pkg.sv
rtl/i2c_master_status_sequencer.sv
tb/i2c_master_status_sequencer_checker.sv
tb/i2c_master_status_sequencer_tb.sv
